/* src/assert_macros.svh */
// Assertion helper macros for the dispatch block.
// Compiled to nothing when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LLD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dispatch: same-cycle check failed");
// next-cycle implication
`define LLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dispatch: next-cycle check failed");
`else
`define LLD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/lld_pkg.sv */
// Shared types and constants for the least-loaded worker dispatch block.
// No dependencies.
package lld_pkg;

	localparam int LLD_MAX_WORKERS = 16;
	localparam int LLD_LOAD_WIDTH  = 16;

	localparam logic [15:0] CAP_RST   = 16'd10;
	localparam logic [4:0]  LIMIT_RST = 5'd1;
	localparam logic [4:0]  INIT_RST  = 5'd0;

	typedef enum logic [1:0] {
		CMD_AUTO    = 2'd0,
		CMD_ASSIGN  = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NO_CAP  = 2'd1,
		STS_BAD_IDX = 2'd2,
		STS_NOT_DLV = 2'd3
	} sts_t;

	typedef enum logic [1:0] {
		REG_MAX_PER_WORKER  = 2'd0,
		REG_WORKER_LIMIT    = 2'd1,
		REG_INITIAL_WORKERS = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_RD,
		ST_MOD,
		ST_RESP
	} state_t;

endpackage

/* src/lld_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lld_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/least_loaded_worker_dispatch.sv */
// Least-loaded worker dispatch: one request in flight at a time.
// Auto assign: the scan reads one load counter per cycle from the load RAM and waits for
// the last read, then the pick state loads the least-loaded worker or grows a new one.
// Directed assign, release: read then write back; bad index or unused command answers directly.
// The next request is accepted once the response state has moved the result to the output.
// Reset: loads read as zero through per-entry valid bits, no workers grown, registers at defaults.
`include "assert_macros.svh"

module least_loaded_worker_dispatch
	import lld_pkg::*;
#(
	parameter int MAX_WORKERS = LLD_MAX_WORKERS,
	parameter int LOAD_WIDTH  = LLD_LOAD_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  target_worker,
	input  logic        delivered,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  worker_index,
	output logic [15:0] worker_load,
	output logic [4:0]  active_workers,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int CW  = $clog2(MAX_WORKERS + 1);
	localparam int WW  = (CW > 5) ? CW : 5;
	localparam int LXW = (LOAD_WIDTH > 16) ? LOAD_WIDTH : 16;
	localparam int IXW = (IW > 4) ? IW : 4;
	localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = {LOAD_WIDTH{1'b1}};

	// configuration registers
	logic [15:0] cap_q;
	logic [4:0]  limit_q;
	logic [4:0]  init_q;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	// control state
	state_t                state_q, state_d;
	logic [CW-1:0]         grown_q;
	logic [CW-1:0]         act_q;
	logic [CW-1:0]         scan_q;
	cmd_t                  cmd_q;
	logic [3:0]            tgt_q;
	logic                  dlv_q;
	logic                  found_q;
	logic [IW-1:0]         best_idx_q;
	logic [LOAD_WIDTH-1:0] best_load_q;
	logic [MAX_WORKERS-1:0] vld_q;
	logic                  rd_vld_s1;
	logic [IW-1:0]         rd_idx_s1;

	// result holding and output registers
	logic [1:0]  res_sts_q;
	logic [3:0]  res_idx_q;
	logic [15:0] res_load_q;
	logic        out_valid_q;

	// active count
	logic [WW-1:0] max_w, lim_w, lim_raw_w, init_raw_w, init_w, act_w;
	logic [WW:0]   sum_w;
	logic [CW-1:0] act_now, lim_now;

	// datapath
	logic                  accept;
	logic                  bad_req;
	logic                  ram_we, ram_re;
	logic [IW-1:0]         ram_waddr, ram_raddr;
	logic [LOAD_WIDTH-1:0] ram_wdata, ram_rdata;
	logic [LOAD_WIDTH-1:0] rd_load;
	logic [LOAD_WIDTH-1:0] new_load;
	logic                  best_upd;
	logic                  scan_issue;
	logic                  grow;
	logic                  res_upd;
	logic [1:0]            res_sts_d;
	logic [3:0]            res_idx_d;
	logic [IW-1:0]         res_widx;
	logic [IXW-1:0]        res_widx_x;
	logic [LXW-1:0]        new_load_x;
	logic                  out_load;

	// ------------------------------------------------------------------
	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RST;
			limit_q <= LIMIT_RST;
			init_q  <= INIT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MAX_PER_WORKER:  cap_q   <= pwdata[15:0];
				REG_WORKER_LIMIT:    limit_q <= pwdata[4:0];
				REG_INITIAL_WORKERS: init_q  <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MAX_PER_WORKER:  prdata = {16'd0, cap_q};
			REG_WORKER_LIMIT:    prdata = {27'd0, limit_q};
			REG_INITIAL_WORKERS: prdata = {27'd0, init_q};
			default:             prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// active worker count: clamped initial count plus grown workers, capped at the clamped limit
	always_comb begin
		max_w      = WW'(MAX_WORKERS);
		lim_raw_w  = WW'(limit_q);
		lim_w      = (lim_raw_w > max_w) ? max_w : lim_raw_w;
		init_raw_w = WW'(init_q);
		init_w     = (init_raw_w > lim_w) ? lim_w : init_raw_w;
		sum_w      = {1'b0, init_w} + (WW + 1)'(grown_q);
		act_w      = (sum_w > {1'b0, lim_w}) ? lim_w : sum_w[WW-1:0];
		act_now    = act_w[CW-1:0];
		lim_now    = lim_w[CW-1:0];
	end

	// ------------------------------------------------------------------
	// load RAM; an entry never written since reset reads as zero
	lld_ram #(
		.WIDTH (LOAD_WIDTH),
		.DEPTH (MAX_WORKERS)
	) u_load_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_load = vld_q[rd_idx_s1] ? ram_rdata : '0;

	// ------------------------------------------------------------------
	// sequencer: next state
	assign accept  = in_valid && (state_q == ST_IDLE);
	assign bad_req = (cmd_t'(cmd) == CMD_UNUSED) || (WW'(target_worker) >= WW'(act_now));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd_t'(cmd) == CMD_AUTO) begin
						state_d = ST_SCAN;
					end else if (bad_req) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_SCAN: begin
				if (scan_q == act_q && !rd_vld_s1) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: state_d = ST_RESP;
			ST_RD:   state_d = ST_MOD;
			ST_MOD:  state_d = ST_RESP;
			ST_RESP: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer: outputs and datapath control
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		ram_re     = 1'b0;
		ram_raddr  = IW'(tgt_q);
		ram_we     = 1'b0;
		ram_waddr  = best_idx_q;
		ram_wdata  = '0;
		new_load   = '0;
		scan_issue = 1'b0;
		grow       = 1'b0;
		res_upd    = 1'b0;
		res_sts_d  = STS_OK;
		res_idx_d  = 4'd0;
		res_widx   = best_idx_q;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// bad index or unused command answers without touching the RAM
				if (accept && cmd_t'(cmd) != CMD_AUTO && bad_req) begin
					res_upd   = 1'b1;
					res_sts_d = STS_BAD_IDX;
					res_idx_d = target_worker;
				end
			end
			ST_SCAN: begin
				if (scan_q < act_q) begin
					scan_issue = 1'b1;
					ram_re     = 1'b1;
					ram_raddr  = scan_q[IW-1:0];
				end
			end
			ST_PICK: begin
				if (found_q && LXW'(best_load_q) < LXW'(cap_q)) begin
					if (dlv_q) begin
						new_load = (best_load_q == LOAD_MAX) ? best_load_q
							: best_load_q + LOAD_WIDTH'(1);
					end else begin
						new_load = best_load_q;
					end
					ram_we    = 1'b1;
					ram_waddr = best_idx_q;
					ram_wdata = new_load;
					res_upd   = 1'b1;
					res_sts_d = dlv_q ? STS_OK : STS_NOT_DLV;
					res_widx  = best_idx_q;
					res_idx_d = res_widx_x[3:0];
				end else if (act_q < lim_now) begin
					// bring up worker number act with a fresh count
					new_load  = LOAD_WIDTH'(dlv_q);
					grow      = 1'b1;
					ram_we    = 1'b1;
					ram_waddr = act_q[IW-1:0];
					ram_wdata = new_load;
					res_upd   = 1'b1;
					res_sts_d = dlv_q ? STS_OK : STS_NOT_DLV;
					res_widx  = act_q[IW-1:0];
					res_idx_d = res_widx_x[3:0];
				end else begin
					res_upd   = 1'b1;
					res_sts_d = STS_NO_CAP;
				end
			end
			ST_RD: begin
				ram_re    = 1'b1;
				ram_raddr = IW'(tgt_q);
			end
			ST_MOD: begin
				if (cmd_q == CMD_ASSIGN) begin
					if (dlv_q) begin
						new_load = (rd_load == LOAD_MAX) ? rd_load
							: rd_load + LOAD_WIDTH'(1);
					end else begin
						new_load = rd_load;
					end
					res_sts_d = dlv_q ? STS_OK : STS_NOT_DLV;
				end else begin
					new_load  = (rd_load != '0) ? rd_load - LOAD_WIDTH'(1) : rd_load;
					res_sts_d = STS_OK;
				end
				ram_we    = 1'b1;
				ram_waddr = IW'(tgt_q);
				ram_wdata = new_load;
				res_upd   = 1'b1;
				res_idx_d = tgt_q;
			end
			ST_RESP: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	assign res_widx_x = IXW'(res_widx);
	assign new_load_x = LXW'(new_load);
	assign best_upd   = rd_vld_s1 && (!found_q || rd_load < best_load_q);

	// ------------------------------------------------------------------
	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grown_q     <= '0;
			vld_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue;
			if (grow) begin
				grown_q <= grown_q + CW'(1);
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (accept) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (scan_issue) begin
					scan_q <= scan_q + CW'(1);
				end
				if (best_upd) begin
					found_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			tgt_q <= target_worker;
			dlv_q <= delivered;
			act_q <= act_now;
		end
		if (ram_re) begin
			rd_idx_s1 <= ram_raddr;
		end
		if (best_upd) begin
			best_idx_q  <= rd_idx_s1;
			best_load_q <= rd_load;
		end
		if (res_upd) begin
			res_sts_q  <= res_sts_d;
			res_idx_q  <= res_idx_d;
			res_load_q <= new_load_x[15:0];
		end
		if (out_load) begin
			status         <= res_sts_q;
			worker_index   <= res_idx_q;
			worker_load    <= res_load_q;
			active_workers <= act_w[4:0];
		end
	end

	assign out_valid = out_valid_q;

	// ------------------------------------------------------------------
	`LLD_ASSERT_IMPL(a_wr_state, clk, arst_n, ram_we, state_q == ST_PICK || state_q == ST_MOD)
	`LLD_ASSERT_IMPL(a_scan_rng, clk, arst_n, rd_vld_s1, CW'(rd_idx_s1) < act_q)
	`LLD_ASSERT_NEXT(a_out_drop, clk, arst_n, out_valid && !out_stall && state_q != ST_RESP, !out_valid)
	`LLD_ASSERT_IMPL(a_one_req, clk, arst_n, accept, state_q == ST_IDLE && !rd_vld_s1)

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Testbench for least_loaded_worker_dispatch: directed and random requests,
// checked against a behavioral predictor. Depends on lld_pkg and the RTL top only.
module testbench;
	import lld_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE      = 24;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 136;

	typedef struct {
		sts_t        status;
		logic [3:0]  idx;
		logic [15:0] load;
		logic [4:0]  active;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_AUTO;
	logic [3:0]  target_worker = 4'd0;
	logic        delivered = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [3:0]  worker_index;
	logic [15:0] worker_load;
	logic [4:0]  active_workers;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	least_loaded_worker_dispatch uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .target_worker(target_worker), .delivered(delivered),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .worker_index(worker_index),
		.worker_load(worker_load), .active_workers(active_workers),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [15:0] worker_load_mdl [16];
	int grown_cnt = 0;
	int cap_cfg   = CAP_RST;
	int limit_cfg = LIMIT_RST;
	int init_cfg  = INIT_RST;

	grant_t expected_grants [$];

	int error_count     = 0;
	int requests_sent   = 0;
	int results_checked = 0;
	int config_writes   = 0;
	int no_cap_seen     = 0;
	int burst_left      = 0;
	int cycle_count     = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				expected_grants.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		if (error_count < 20)
			$display("MISMATCH %s: got %0d want %0d (result %0d, cycle %0d)",
				what, got, want, results_checked, cycle_count);
		error_count++;
	endtask

	function automatic int eff_limit();
		return (limit_cfg > LLD_MAX_WORKERS) ? LLD_MAX_WORKERS : limit_cfg;
	endfunction

	function automatic int active_now();
		int lim;
		int a;
		lim = eff_limit();
		a = (init_cfg > lim) ? lim : init_cfg;
		a = a + grown_cnt;
		return (a > lim) ? lim : a;
	endfunction

	function automatic void bump_load(int w, logic dlv);
		if (dlv && worker_load_mdl[w] != 16'hFFFF)
			worker_load_mdl[w] = worker_load_mdl[w] + 16'd1;
	endfunction

	function automatic grant_t predict_dispatch(cmd_t c, logic [3:0] tgt, logic dlv);
		grant_t g;
		int act;
		int best;
		sts_t st;
		act = active_now();
		if (dlv) st = STS_OK;
		else st = STS_NOT_DLV;
		g.status = STS_BAD_IDX;
		g.idx = tgt;
		g.load = 16'd0;
		if (c == CMD_AUTO) begin
			best = 0;
			for (int i = 1; i < act; i++)
				if (worker_load_mdl[i] < worker_load_mdl[best]) best = i;
			if (act > 0 && worker_load_mdl[best] < cap_cfg) begin
				bump_load(best, dlv);
				g.status = st;
				g.idx = best[3:0];
				g.load = worker_load_mdl[best];
			end else if (act < eff_limit()) begin
				// grow the pool; the new worker starts from a cleared counter
				grown_cnt++;
				worker_load_mdl[act] = {15'd0, dlv};
				g.status = st;
				g.idx = act[3:0];
				g.load = worker_load_mdl[act];
			end else begin
				g.status = STS_NO_CAP;
				g.idx = 4'd0;
			end
		end else if (c == CMD_UNUSED || tgt >= act) begin
			g.status = STS_BAD_IDX;
		end else if (c == CMD_ASSIGN) begin
			bump_load(tgt, dlv);
			g.status = st;
			g.load = worker_load_mdl[tgt];
		end else begin
			if (worker_load_mdl[tgt] != 16'd0) worker_load_mdl[tgt] = worker_load_mdl[tgt] - 16'd1;
			g.status = STS_OK;
			g.load = worker_load_mdl[tgt];
		end
		g.active = 5'(active_now());
		return g;
	endfunction

	// request sender: bursts of random length with random gaps
	task automatic send_req(cmd_t c, logic [3:0] tgt, logic dlv);
		int gap;
		grant_t g_pred;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= c;
		target_worker <= tgt;
		delivered <= dlv;
		do @(posedge clk); while (in_stall);
		g_pred = predict_dispatch(c, tgt, dlv);
		expected_grants = {expected_grants, g_pred};
		requests_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_grants.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_access(reg_idx_t r, logic wr, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr) begin
			config_writes++;
			case (r)
				REG_MAX_PER_WORKER:  cap_cfg = int'(v[15:0]);
				REG_WORKER_LIMIT:    limit_cfg = int'(v[4:0]);
				REG_INITIAL_WORKERS: init_cfg = int'(v[4:0]);
				default: ;
			endcase
		end else if (prdata !== v) begin
			report_mismatch("register readback", prdata, v);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// drains outstanding results first, so the block is idle while registers are written
	task automatic set_config(int cap, int lim, int init);
		drain();
		apb_access(REG_MAX_PER_WORKER, 1'b1, cap);
		apb_access(REG_WORKER_LIMIT, 1'b1, lim);
		apb_access(REG_INITIAL_WORKERS, 1'b1, init);
		apb_access(REG_MAX_PER_WORKER, 1'b0, cap);
		apb_access(REG_WORKER_LIMIT, 1'b0, lim);
		apb_access(REG_INITIAL_WORKERS, 1'b0, init);
	endtask

	// result checker
	always @(posedge clk) begin
		grant_t want_g;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_grants.size() == 0) begin
				report_mismatch("result with no request pending", status, 0);
			end else begin
				want_g = expected_grants.pop_front();
				if (status !== want_g.status) report_mismatch("status", status, want_g.status);
				if (worker_index !== want_g.idx)
					report_mismatch("worker_index", worker_index, want_g.idx);
				if (worker_load !== want_g.load)
					report_mismatch("worker_load", worker_load, want_g.load);
				if (active_workers !== want_g.active)
					report_mismatch("active_workers", active_workers, want_g.active);
				if (want_g.status == STS_NO_CAP) no_cap_seen++;
				results_checked++;
			end
		end
	end

	// receiver stall pattern, changes mode every so often
	int stall_left = 0;
	int stall_mode = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= (stall_left % 11) < 6;
		endcase
	end

	// register defaults: one worker allowed, none active yet
	task automatic test_idle_defaults();
		send_req(CMD_UNUSED, 4'd15, 1'b1);
		send_req(CMD_RELEASE, 4'd0, 1'b1);  // nothing active yet
		send_req(CMD_AUTO, 4'd0, 1'b0);     // activates worker 0, not delivered
		send_req(CMD_AUTO, 4'd7, 1'b1);
		send_req(CMD_ASSIGN, 4'd0, 1'b1);
		send_req(CMD_ASSIGN, 4'd0, 1'b0);
		send_req(CMD_RELEASE, 4'd0, 1'b0);
		send_req(CMD_RELEASE, 4'd0, 1'b1);
		send_req(CMD_RELEASE, 4'd0, 1'b1);  // load stays at zero
		send_req(CMD_ASSIGN, 4'd15, 1'b1);
	endtask

	task automatic test_capacity_exhaust();
		set_config(1, 2, 0);
		send_req(CMD_AUTO, 4'd0, 1'b1);
		send_req(CMD_AUTO, 4'd0, 1'b1);
		send_req(CMD_AUTO, 4'd0, 1'b0);     // pool full, cap reached
		send_req(CMD_ASSIGN, 4'd1, 1'b1);
	endtask

	task automatic test_zero_cap_full_pool();
		set_config(0, 16, 16);
		send_req(CMD_AUTO, 4'd3, 1'b1);
		send_req(CMD_ASSIGN, 4'd15, 1'b1);
		send_req(CMD_RELEASE, 4'd15, 1'b0);
		send_req(CMD_RELEASE, 4'd15, 1'b1);
		send_req(CMD_UNUSED, 4'd0, 1'b0);
	endtask

	task automatic test_wide_cap();
		set_config(16'hFFFF, 16, 3);
		send_req(CMD_AUTO, 4'd0, 1'b1);
		send_req(CMD_AUTO, 4'd0, 1'b1);
		send_req(CMD_ASSIGN, 4'd9, 1'b1);
	endtask

	task automatic test_random_traffic();
		int cap;
		int lim;
		int init;
		int act;
		int hi;
		int pick;
		cmd_t c;
		logic [3:0] tgt;
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: cap = $urandom_range(1, 4);
				1: cap = $urandom_range(1, 12);
				2: cap = $urandom_range(0, 1) ? 16'hFFFF : $urandom_range(1, 65535);
				default: cap = $urandom_range(0, 3);
			endcase
			init = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
			// leave a little room so the pool can still grow
			lim = grown_cnt + ((init > 16) ? 16 : init) + $urandom_range(1, 2);
			if (lim > 16) lim = 16;
			if (p == 3) lim = 1;
			if (p == 7) begin
				lim = 16;
				init = 16;
			end
			set_config(cap, lim, init);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) c = CMD_AUTO;
				else if (pick < 65) c = CMD_ASSIGN;
				else if (pick < 92) c = CMD_RELEASE;
				else c = CMD_UNUSED;
				act = active_now();
				hi = (act > 15) ? 15 : ((act > 0) ? act : 1);
				if ($urandom_range(0, 9) < 7) tgt = 4'($urandom_range(0, hi));
				else tgt = 4'($urandom_range(0, 15));
				send_req(c, tgt, $urandom_range(0, 4) != 0);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < 16; i++) worker_load_mdl[i] = 16'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_defaults();
		test_capacity_exhaust();
		test_zero_cap_full_pool();
		test_wide_cap();
		test_random_traffic();
		drain();
		$display("%0d requests sent, %0d results checked (%0d no-capacity), %0d config writes",
			requests_sent, results_checked, no_cap_seen, config_writes);
		$display("pool grew by %0d workers; %0d mismatches", grown_cnt, error_count);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
